[rtl/core/tdhb_pkg.sv]
// Package with constants and types shared by the two-dimensional histogram binner.
`timescale 1ns / 1ps
package tdhb_pkg;
  localparam int MaxXBins = 64;
  localparam int MaxYBins = 64;
  localparam int CountWidth = 32;
  localparam int Depth = MaxXBins * MaxYBins;
  localparam int AddrWidth = $clog2(Depth);
  localparam int XbWidth = $clog2(MaxXBins);
  localparam int YbWidth = $clog2(MaxYBins);
  localparam int DivWidth = 33;
  localparam int CfgWidth = 32;

  typedef enum logic [1:0] {
    StCounted = 2'd0,
    StNull    = 2'd1,
    StRange   = 2'd2,
    StRead    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CfgXLower = 3'd0,
    CfgXWidth = 3'd1,
    CfgXBins  = 3'd2,
    CfgYLower = 3'd3,
    CfgYWidth = 3'd4,
    CfgYBins  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SIdle,
    SDiv,
    SIndex,
    SRead,
    SWrite
  } fsm_e;
endpackage

[rtl/core/tdhb_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module tdhb_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tdhb_pkg::DivWidth-1:0] dividend_i,
  input  logic [30:0]                   divisor_i,
  output logic                          done_o,
  output logic [tdhb_pkg::DivWidth-1:0] quotient_o
);
  import tdhb_pkg::*;

  logic [DivWidth-1:0] quot_q, quot_d;
  logic [31:0]         rem_q, rem_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [32:0]         trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[DivWidth-1]} - {2'b00, divisor_i};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'(DivWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quot_d = {quot_q[DivWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quot_q[DivWidth-1]};
        quot_d = {quot_q[DivWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o     = busy_q && (cnt_q == 6'd1);
  assign quotient_o = quot_d;
endmodule

[rtl/core/tdhb_count_ram.sv]
// Count store with a registered read port and a clearing pass after reset.
`timescale 1ns / 1ps
module tdhb_count_ram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tdhb_pkg::AddrWidth-1:0]  raddr_i,
  output logic [tdhb_pkg::CountWidth-1:0] rdata_o,
  input  logic                            we_i,
  input  logic [tdhb_pkg::AddrWidth-1:0]  waddr_i,
  input  logic [tdhb_pkg::CountWidth-1:0] wdata_i,
  output logic                            ready_o
);
  import tdhb_pkg::*;

  logic [CountWidth-1:0] mem [Depth];
  logic [AddrWidth:0]    clr_q, clr_d;
  logic                  clearing;
  logic                  wen;
  logic [AddrWidth-1:0]  wa;
  logic [CountWidth-1:0] wd;

  assign clearing = !clr_q[AddrWidth];
  assign clr_d    = clearing ? clr_q + 1'b1 : clr_q;
  assign wen      = clearing || we_i;
  assign wa       = clearing ? clr_q[AddrWidth-1:0] : waddr_i;
  assign wd       = clearing ? '0 : wdata_i;
  assign ready_o  = !clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[wa] <= wd;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/core/two_dim_histogram_binner.sv]
// Top level of the two-dimensional histogram binner.
// An add word passes through the bit-serial bin divisions, the flat index, the store read,
// the write-back and the output register. An out-of-range add ends after the flat index; a
// read word skips the divisions and also ends after the flat index when out of range; a null
// goes straight to the output register. The result strobe is raised when busy is already low again.
// After reset a clearing pass zeroes all 4096 entries of the count store while busy is high.
`timescale 1ns / 1ps
module two_dim_histogram_binner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        action_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic        x_is_null_i,
  input  logic        y_is_null_i,
  input  logic [5:0]  read_x_bin_i,
  input  logic [5:0]  read_y_bin_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [11:0] bin_index_o,
  output logic [31:0] bin_count_o
);
  import tdhb_pkg::*;

  logic signed [31:0] x_lower_q, y_lower_q;
  logic [30:0] x_width_q, y_width_q;
  logic [6:0]  x_bins_q, y_bins_q;
  logic [6:0]  xn, yn;
  fsm_e state_q, state_d;

  logic signed [33:0] x_diff, y_diff;
  logic [DivWidth-1:0] xq, yq;
  logic x_done, y_done, div_start, ram_ready;
  logic x_neg_q, y_neg_q, x_neg_d, y_neg_d;
  logic [DivWidth-1:0] xq_q, yq_q;
  logic [AddrWidth-1:0] addr_q, addr_d;
  logic [5:0] xb_sel, yb_sel;
  logic in_rng;
  logic read_q, read_d;
  logic [CountWidth-1:0] rdata, inc;
  logic we;
  logic [1:0] st_q, st_d;
  logic [11:0] idx_q, idx_d;
  logic [31:0] cnt_q, cnt_d;
  logic vld_q, vld_d;

  assign xn = (x_bins_q > 7'(MaxXBins)) ? 7'(MaxXBins) : x_bins_q;
  assign yn = (y_bins_q > 7'(MaxYBins)) ? 7'(MaxYBins) : y_bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lower_q <= '0;
      x_width_q <= 31'd65536;
      x_bins_q  <= 7'd64;
      y_lower_q <= '0;
      y_width_q <= 31'd65536;
      y_bins_q  <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgXLower: x_lower_q <= cfg_data_i;
        CfgXWidth: x_width_q <= cfg_data_i[30:0];
        CfgXBins:  x_bins_q  <= cfg_data_i[6:0];
        CfgYLower: y_lower_q <= cfg_data_i;
        CfgYWidth: y_width_q <= cfg_data_i[30:0];
        CfgYBins:  y_bins_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign x_diff = 34'(x_value_i) - 34'(x_lower_q);
  assign y_diff = 34'(y_value_i) - 34'(y_lower_q);

  tdhb_divider u_xdiv (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(x_diff[DivWidth-1:0]),
    .divisor_i(x_width_q), .done_o(x_done), .quotient_o(xq)
  );
  tdhb_divider u_ydiv (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(y_diff[DivWidth-1:0]),
    .divisor_i(y_width_q), .done_o(y_done), .quotient_o(yq)
  );

  tdhb_count_ram u_ram (
    .clk_i, .rst_ni, .raddr_i(addr_q), .rdata_o(rdata), .we_i(we),
    .waddr_i(addr_q), .wdata_i(inc), .ready_o(ram_ready)
  );

  assign inc = (&rdata) ? rdata : rdata + 1'b1;

  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    x_neg_d = x_neg_q;
    y_neg_d = y_neg_q;
    addr_d = addr_q;
    read_d = read_q;
    st_d = st_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    vld_d = 1'b0;
    we = 1'b0;
    busy = (state_q != SIdle) || !ram_ready;
    xb_sel = read_q ? xq_q[5:0] : xq_q[5:0];
    yb_sel = yq_q[5:0];
    in_rng = (xq_q < DivWidth'(xn)) && (yq_q < DivWidth'(yn)) && !x_neg_q && !y_neg_q;
    case (state_q)
      SIdle: begin
        if (start && ram_ready) begin
          read_d = action_i;
          if (action_i) begin
            x_neg_d = 1'b0;
            y_neg_d = 1'b0;
            state_d = SIndex;
          end else if (x_is_null_i || y_is_null_i) begin
            st_d = StNull; idx_d = '0; cnt_d = '0; vld_d = 1'b1;
          end else begin
            div_start = 1'b1;
            x_neg_d = x_diff[33];
            y_neg_d = y_diff[33];
            state_d = SDiv;
          end
        end
      end
      SDiv: begin
        if (x_done && y_done) begin
          state_d = SIndex;
        end
      end
      SIndex: begin
        if (!in_rng) begin
          st_d = StRange; idx_d = '0; cnt_d = '0; vld_d = 1'b1;
          state_d = SIdle;
        end else begin
          addr_d = AddrWidth'(xb_sel * yn + 13'(yb_sel));
          state_d = SRead;
        end
      end
      SRead: state_d = SWrite;
      SWrite: begin
        idx_d = 12'(addr_q);
        if (read_q) begin
          st_d = StRead; cnt_d = rdata;
        end else begin
          st_d = StCounted; cnt_d = inc; we = 1'b1;
        end
        vld_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_neg_q <= x_neg_d;
    y_neg_q <= y_neg_d;
    addr_q <= addr_d;
    read_q <= read_d;
    st_q <= st_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    if (state_q == SIdle && start && ram_ready && action_i) begin
      xq_q <= DivWidth'(read_x_bin_i);
      yq_q <= DivWidth'(read_y_bin_i);
    end else if (state_q == SDiv && x_done) begin
      xq_q <= xq;
      yq_q <= yq;
    end
  end

  assign result_valid_o = vld_q;
  assign status_o = st_q;
  assign bin_index_o = idx_q;
  assign bin_count_o = cnt_q;
endmodule

[dv/two_dim_histogram_binner_tb.sv]
// Testbench for the two-dimensional histogram binner: directed and random words with checking.
`timescale 1ns / 1ps
module two_dim_histogram_binner_tb;
  import tdhb_pkg::*;

  localparam logic [2:0] CfgUnused = 3'd6;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic               action;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               x_null;
    logic               y_null;
    logic [5:0]         rd_x;
    logic [5:0]         rd_y;
  } sample_t;

  typedef struct {
    status_e     status;
    logic [11:0] index;
    logic [31:0] count;
  } bin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic action_i = 1'b0;
  logic signed [31:0] x_value_i = '0;
  logic signed [31:0] y_value_i = '0;
  logic x_is_null_i = 1'b0;
  logic y_is_null_i = 1'b0;
  logic [5:0] read_x_bin_i = '0;
  logic [5:0] read_y_bin_i = '0;
  logic result_valid_o;
  logic [1:0] status_o;
  logic [11:0] bin_index_o;
  logic [31:0] bin_count_o;

  logic signed [31:0] x_lo, y_lo;
  logic [30:0] x_w, y_w;
  logic [6:0] x_n, y_n;
  logic [31:0] hist[Depth];
  bin_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int idle_pct = 0;
  longint cycles = 0;

  two_dim_histogram_binner uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int eff_bins(logic [6:0] n);
    return (n > 64) ? 64 : int'(n);
  endfunction

  function automatic bit locate(logic signed [31:0] v, logic signed [31:0] lo,
                                logic [30:0] w, int n, output int b);
    longint diff;
    longint q;
    diff = longint'(v) - longint'(lo);
    b = 0;
    if (w == 0 || diff < 0) return 1'b0;
    q = diff / longint'(w);
    if (q >= n) return 1'b0;
    b = int'(q);
    return 1'b1;
  endfunction

  function automatic bin_result_t bin_sample(sample_t s);
    bin_result_t r;
    int xn, yn, xb, yb, idx;
    xn = eff_bins(x_n);
    yn = eff_bins(y_n);
    r = '{StRange, '0, '0};
    if (s.action) begin
      if (s.rd_x < xn && s.rd_y < yn) begin
        idx = s.rd_x * yn + s.rd_y;
        r = '{StRead, idx[11:0], hist[idx]};
      end
    end else if (s.x_null || s.y_null) begin
      r.status = StNull;
    end else if (locate(s.x_value, x_lo, x_w, xn, xb) && locate(s.y_value, y_lo, y_w, yn, yb)) begin
      idx = xb * yn + yb;
      if (hist[idx] != 32'hFFFF_FFFF) hist[idx] = hist[idx] + 1;
      r = '{StCounted, idx[11:0], hist[idx]};
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("Result word with nothing expected: status %0d", status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (bin_index_o !== want.index) begin
          $error("bin_index: expected %0d, got %0d", want.index, bin_index_o);
          errors++;
        end
        if (bin_count_o !== want.count) begin
          $error("bin_count: expected %0d, got %0d", want.count, bin_count_o);
          errors++;
        end
      end
    end
  end

  // Called at a rising edge; leaves start high unless an idle gap is drawn, so back-to-back words need no gap.
  task automatic send_word(sample_t s);
    start <= 1'b1;
    action_i <= s.action;
    x_value_i <= s.x_value;
    y_value_i <= s.y_value;
    x_is_null_i <= s.x_null;
    y_is_null_i <= s.y_null;
    read_x_bin_i <= s.rd_x;
    read_y_bin_i <= s.rd_y;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    pending_results.push_back(bin_sample(s));
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgXLower: x_lo = data;
      CfgXWidth: x_w = data[30:0];
      CfgXBins:  x_n = data[6:0];
      CfgYLower: y_lo = data;
      CfgYWidth: y_w = data[30:0];
      CfgYBins:  y_n = data[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] xl, logic [31:0] xw, logic [31:0] xn,
                           logic [31:0] yl, logic [31:0] yw, logic [31:0] yn);
    write_reg(CfgXLower, xl);
    write_reg(CfgXWidth, xw);
    write_reg(CfgXBins, xn);
    write_reg(CfgYLower, yl);
    write_reg(CfgYWidth, yw);
    write_reg(CfgYBins, yn);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_t add_pair(logic [31:0] x, logic [31:0] y, bit xz, bit yz);
    return '{1'b0, x, y, xz, yz, 6'($urandom), 6'($urandom)};
  endfunction

  function automatic sample_t read_bin(logic [5:0] rx, logic [5:0] ry);
    return '{1'b1, $urandom, $urandom, 1'($urandom), 1'($urandom), rx, ry};
  endfunction

  function automatic logic [31:0] near_value(logic signed [31:0] lo, logic [30:0] w, int n);
    longint span;
    span = longint'(w) * (n + 1);
    if (span > 64'hFFFF_FFFE) span = 64'hFFFF_FFFE;
    if ($urandom_range(9) == 0) return lo - 1;
    return 32'(longint'(lo) + longint'($urandom_range(0, 32'(span))));
  endfunction

  function automatic sample_t random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65)
      return add_pair(near_value(x_lo, x_w, eff_bins(x_n)),
                      near_value(y_lo, y_w, eff_bins(y_n)), 1'b0, 1'b0);
    if (pick < 75) return add_pair($urandom, $urandom, 1'b0, 1'b0);
    if (pick < 85) return add_pair($urandom, $urandom, 1'($urandom), 1'b1);
    if (pick < 95)
      return read_bin(6'($urandom_range(0, eff_bins(x_n) - 1)),
                      6'($urandom_range(0, eff_bins(y_n) - 1)));
    return read_bin(6'($urandom), 6'($urandom));
  endfunction

  task automatic test_directed_defaults();
    idle_pct = 0;
    send_word(add_pair(32'h0, 32'h0, 1'b0, 1'b0));
    send_word(add_pair(32'h0000_8000, 32'h0000_FFFF, 1'b0, 1'b0));
    send_word(add_pair(32'h003F_FFFF, 32'h003F_0000, 1'b0, 1'b0));
    send_word(add_pair(32'h0040_0000, 32'h0, 1'b0, 1'b0));
    send_word(add_pair(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_word(add_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
    send_word(add_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0));
    send_word(add_pair(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0));
    send_word(add_pair(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1));
    send_word(add_pair(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1));
    send_word(read_bin(6'd0, 6'd0));
    send_word(read_bin(6'd63, 6'd63));
    send_word(read_bin(6'd0, 6'd63));
    drain();
  endtask

  task automatic test_config_extremes();
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd127, 32'h7FFF_FFFF, 32'd1, 32'd1);
    send_word(add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0));
    send_word(add_pair(32'h8000_0000, 32'h7FFF_FFFE, 1'b0, 1'b0));
    send_word(read_bin(6'd1, 6'd0));
    send_word(read_bin(6'd0, 6'd1));
    drain();
    configure(32'h0, 32'h8000_0000, 32'd0, 32'h0, 32'h0, 32'd64);
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_word(add_pair(32'h0, 32'h0, 1'b0, 1'b0));
    send_word(read_bin(6'd0, 6'd0));
    drain();
    configure(32'h0, 32'd1, 32'd2, 32'h0, 32'h0, 32'd2);
    send_word(add_pair(32'h1, 32'h1, 1'b0, 1'b0));
    drain();
  endtask

  task automatic test_random_phase(int pct, int n);
    idle_pct = pct;
    for (int i = 0; i < n; i++) send_word(random_word());
    drain();
  endtask

  initial begin
    foreach (hist[i]) hist[i] = '0;
    x_lo = 0; y_lo = 0; x_w = 31'd65536; y_w = 31'd65536; x_n = 7'd64; y_n = 7'd64;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);

    test_directed_defaults();
    test_config_extremes();
    configure($urandom, 32'h0001_0000, 32'd8, $urandom, 32'h0000_4000, 32'd8);
    test_random_phase(0, 150);
    configure($urandom, $urandom_range(1, 1 << 20), 32'd64, $urandom,
              $urandom_range(1, 1 << 20), 32'd64);
    test_random_phase(75, 150);
    configure(32'hC000_0000, 32'h0100_0000, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3);
    test_random_phase(23, 150);
    configure($urandom, 32'd3, 32'd1, $urandom, 32'd5, 32'd5);
    test_random_phase(0, 150);

    $display("Sent %0d words over default, extreme and random bin settings;", words_sent);
    $display("checked %0d result words with idle gaps of 0, 23 and 75 percent.", results_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/tdhb_pkg.sv
rtl/core/tdhb_divider.sv
rtl/core/tdhb_count_ram.sv
rtl/core/two_dim_histogram_binner.sv
dv/two_dim_histogram_binner_tb.sv
